[rtl/ndt_pkg.sv]
package ndt_pkg;

  // Table geometry
  localparam int TableDepth = 8;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Listing limits
  localparam int MaxResults = 8;
  localparam int LimW       = 4;
  localparam int ResW       = $clog2(MaxResults + 1);
  localparam int CmpW       = (CntW > ResW) ? CntW : ResW;

  // Field widths
  localparam int AddrW  = 48;
  localparam int DbmW   = 8;
  localparam int RecW   = 8;
  localparam int ModelW = 16;
  localparam int TimeW  = 32;

  // Configuration register map
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgMaxAge   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHoldAges = 1'b1;

  localparam logic [TimeW-1:0] AgeReset = 32'd30000;

  // Item kinds
  localparam logic KindSight = 1'b0;
  localparam logic KindList  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_WRITE,
    ST_AGE,
    ST_SEL,
    ST_EMIT
  } ndt_state_e;

  // One stored table entry
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [DbmW-1:0]   dbm;
    logic [RecW-1:0]   rec_type;
    logic [ModelW-1:0] model;
    logic [TimeW-1:0]  seen_ms;
  } entry_t;

  // Incoming transaction
  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  addr;
    logic [DbmW-1:0]   dbm;
    logic [RecW-1:0]   rec_type;
    logic [ModelW-1:0] model;
    logic [TimeW-1:0]  now_ms;
    logic [LimW-1:0]   max_count;
  } item_t;

  // Outgoing listed entry
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [DbmW-1:0]   dbm;
    logic [RecW-1:0]   rec_type;
    logic [ModelW-1:0] model;
    logic [TimeW-1:0]  age_ms;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [TimeW-1:0] max_age_ms;
    logic             hold_ages;
  } cfg_t;

  // Sequencer to top level
  typedef struct packed {
    logic    busy;
    logic    res_valid;
    result_t res;
  } seq_status_t;

endpackage

[rtl/ndt_ram.sv]
module ndt_ram (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ndt_pkg::IdxW-1:0] waddr_i,
  input  ndt_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [ndt_pkg::IdxW-1:0] raddr_i,
  output ndt_pkg::entry_t       rdata_o
);
  import ndt_pkg::*;

  entry_t mem [TableDepth];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ndt_seq.sv]
module ndt_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ndt_pkg::item_t       item_i,
  input  ndt_pkg::cfg_t        cfg_i,
  input  logic                 res_ready_i,
  output ndt_pkg::seq_status_t status_o
);
  import ndt_pkg::*;

  ndt_state_e state_q, state_d;

  // Latched transaction
  item_t it_q, it_d;

  // Per-entry flags
  logic [TableDepth-1:0] valid_q, valid_d;
  logic [TableDepth-1:0] taken_q, taken_d;

  // Walk over the memory: issue counter and read-data tag
  logic [CntW-1:0] issue_q, issue_d;
  logic            rdv_q, rdv_d;
  logic [IdxW-1:0] rdi_q, rdi_d;

  // Sighting search results
  logic            match_hit_q, match_hit_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  logic            free_hit_q, free_hit_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [IdxW-1:0] weak_idx_q, weak_idx_d;
  logic [DbmW-1:0] weak_dbm_q, weak_dbm_d;

  // Listing bookkeeping
  logic [CntW-1:0] keep_q, keep_d;
  logic [ResW-1:0] res_n_q, res_n_d;
  logic [ResW-1:0] emit_q, emit_d;
  logic            best_hit_q, best_hit_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  entry_t          best_q, best_d;

  // Memory interface
  logic            rd_en;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  logic             walking;
  logic             walk_done;
  logic [TimeW-1:0] age;
  logic             res_last;
  logic [ResW-1:0]  lim_sat;

  ndt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Walk control: one read issued per cycle, read data tagged in the next cycle
  assign walking   = (state_q == ST_FIND) || (state_q == ST_AGE) || (state_q == ST_SEL);
  assign rd_en     = walking && (issue_q != CntW'(TableDepth));
  assign raddr     = issue_q[IdxW-1:0];
  assign walk_done = walking && (issue_q == CntW'(TableDepth)) && !rdv_q;

  assign age      = it_q.now_ms - rdata.seen_ms;
  assign res_last = (ResW'(emit_q + 1'b1) == res_n_q);
  assign lim_sat  = (it_d.max_count > LimW'(MaxResults)) ? ResW'(MaxResults)
                                                          : ResW'(it_d.max_count);

  // Write back the chosen slot of a sighting
  always_comb begin
    we    = (state_q == ST_WRITE);
    wdata = '{addr: it_q.addr, dbm: it_q.dbm, rec_type: it_q.rec_type,
              model: it_q.model, seen_ms: it_q.now_ms};
    priority if (match_hit_q) begin
      waddr = match_idx_q;
    end else if (free_hit_q) begin
      waddr = free_idx_q;
    end else begin
      waddr = weak_idx_q;
    end
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    it_d        = it_q;
    valid_d     = valid_q;
    taken_d     = taken_q;
    issue_d     = rd_en ? CntW'(issue_q + 1'b1) : issue_q;
    rdv_d       = rd_en;
    rdi_d       = rd_en ? raddr : rdi_q;
    match_hit_d = match_hit_q;
    match_idx_d = match_idx_q;
    free_hit_d  = free_hit_q;
    free_idx_d  = free_idx_q;
    weak_idx_d  = weak_idx_q;
    weak_dbm_d  = weak_dbm_q;
    keep_d      = keep_q;
    res_n_d     = res_n_q;
    emit_d      = emit_q;
    best_hit_d  = best_hit_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;

    status_o.busy      = (state_q != ST_IDLE);
    status_o.res_valid = (state_q == ST_EMIT);
    status_o.res       = '{addr: best_q.addr, dbm: best_q.dbm, rec_type: best_q.rec_type,
                           model: best_q.model, age_ms: it_q.now_ms - best_q.seen_ms,
                           last: res_last};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          it_d        = item_i;
          issue_d     = '0;
          match_hit_d = 1'b0;
          free_hit_d  = 1'b0;
          keep_d      = '0;
          res_n_d     = lim_sat;
          priority if (item_i.kind == KindSight) begin
            state_d = ST_FIND;
          end else if (item_i.max_count != '0) begin
            state_d = ST_AGE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // Look for the address, the first free slot and the weakest slot
      ST_FIND: begin
        if (rdv_q) begin
          if (valid_q[rdi_q] && (rdata.addr == it_q.addr) && !match_hit_q) begin
            match_hit_d = 1'b1;
            match_idx_d = rdi_q;
          end
          if (!valid_q[rdi_q] && !free_hit_q) begin
            free_hit_d = 1'b1;
            free_idx_d = rdi_q;
          end
          if ((rdi_q == '0) || ($signed(rdata.dbm) < $signed(weak_dbm_q))) begin
            weak_idx_d = rdi_q;
            weak_dbm_d = rdata.dbm;
          end
        end
        if (walk_done) begin
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        valid_d[waddr] = 1'b1;
        state_d        = ST_IDLE;
      end

      // Drop stale entries and count the ones that stay
      ST_AGE: begin
        if (rdv_q && valid_q[rdi_q]) begin
          if (!cfg_i.hold_ages && (age > cfg_i.max_age_ms)) begin
            valid_d[rdi_q] = 1'b0;
          end else begin
            keep_d = CntW'(keep_q + 1'b1);
          end
        end
        if (walk_done) begin
          if (CmpW'(keep_q) < CmpW'(res_n_q)) begin
            res_n_d = ResW'(keep_q);
          end
          issue_d    = '0;
          emit_d     = '0;
          taken_d    = '0;
          best_hit_d = 1'b0;
          if (keep_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SEL;
          end
        end
      end

      // Pick the strongest untaken entry, lowest index on ties
      ST_SEL: begin
        if (rdv_q && valid_q[rdi_q] && !taken_q[rdi_q] &&
            (!best_hit_q || ($signed(rdata.dbm) > $signed(best_q.dbm)))) begin
          best_hit_d = 1'b1;
          best_idx_d = rdi_q;
          best_d     = rdata;
        end
        if (walk_done) begin
          state_d = ST_EMIT;
        end
      end

      // Hand the result over, then start the next pass or finish
      ST_EMIT: begin
        if (res_ready_i) begin
          taken_d[best_idx_q] = 1'b1;
          emit_d              = ResW'(emit_q + 1'b1);
          issue_d             = '0;
          best_hit_d          = 1'b0;
          state_d             = res_last ? ST_IDLE : ST_SEL;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      taken_q     <= '0;
      issue_q     <= '0;
      rdv_q       <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
      keep_q      <= '0;
      res_n_q     <= '0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      taken_q     <= taken_d;
      issue_q     <= issue_d;
      rdv_q       <= rdv_d;
      match_hit_q <= match_hit_d;
      free_hit_q  <= free_hit_d;
      best_hit_q  <= best_hit_d;
      keep_q      <= keep_d;
      res_n_q     <= res_n_d;
      emit_q      <= emit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    it_q        <= it_d;
    rdi_q       <= rdi_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    weak_idx_q  <= weak_idx_d;
    weak_dbm_q  <= weak_dbm_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
  end

endmodule

[rtl/nearby_device_table.sv]
// Table of up to TableDepth radio devices keyed by a 48-bit address, held in
// one synchronous memory that a sequencer walks one entry per cycle. A
// sighting (kind 0) refreshes the entry with the same address, else fills
// the lowest free entry, else replaces the weakest entry (lowest index on
// ties), and returns nothing. A list request (kind 1) with a nonzero
// max_count first walks the table once to drop entries older than
// max_age_ms (unless hold_ages is set), then emits up to min(max_count, 8)
// entries strongest first, lowest index on ties, the last one marked by
// last_entry. Every result needs a full selection walk over the memory read
// port, and the output side can stall the run. A list request with
// max_count 0 returns nothing and drops nothing. One item is worked on at a
// time; the finished result sits in an output register so a new item can
// be taken while it waits.
module nearby_device_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [ndt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ndt_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [ndt_pkg::AddrW-1:0]     dev_addr_i,
  input  logic signed [ndt_pkg::DbmW-1:0] signal_dbm_i,
  input  logic [ndt_pkg::RecW-1:0]      rec_type_i,
  input  logic [ndt_pkg::ModelW-1:0]    model_code_i,
  input  logic [ndt_pkg::TimeW-1:0]     now_ms_i,
  input  logic [ndt_pkg::LimW-1:0]      max_count_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ndt_pkg::AddrW-1:0]     entry_addr_o,
  output logic signed [ndt_pkg::DbmW-1:0] entry_dbm_o,
  output logic [ndt_pkg::RecW-1:0]      entry_rec_type_o,
  output logic [ndt_pkg::ModelW-1:0]    entry_model_o,
  output logic [ndt_pkg::TimeW-1:0]     entry_age_ms_o,
  output logic                          last_entry_o
);
  import ndt_pkg::*;

  cfg_t        cfg_q, cfg_d;
  item_t       item;
  seq_status_t seq_st;
  logic        res_ready;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxAge:   cfg_d.max_age_ms = cfg_data_i[TimeW-1:0];
        CfgHoldAges: cfg_d.hold_ages  = cfg_data_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_age_ms: AgeReset, hold_ages: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pack the incoming transaction
  assign item = '{kind: kind_i, addr: dev_addr_i, dbm: signal_dbm_i,
                  rec_type: rec_type_i, model: model_code_i, now_ms: now_ms_i,
                  max_count: max_count_i};

  assign in_stall_o = seq_st.busy;

  ndt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .res_ready_i (res_ready),
    .status_o    (seq_st)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (seq_st.res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_st.res_valid && res_ready) begin
      out_q <= seq_st.res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_addr_o     = out_q.addr;
  assign entry_dbm_o      = out_q.dbm;
  assign entry_rec_type_o = out_q.rec_type;
  assign entry_model_o    = out_q.model;
  assign entry_age_ms_o   = out_q.age_ms;
  assign last_entry_o     = out_q.last;

  // A result offered by the sequencer holds until the output register takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_st.res_valid && !res_ready |=> seq_st.res_valid && $stable(seq_st.res))
    else $error("sequencer result changed while waiting");

  // A list request asking for nothing leaves the block idle at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KindList) && (max_count_i == '0)
    |=> !in_stall_o)
    else $error("zero-count list request kept the block busy");

  // While a result that is not the last waits, the run is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |-> in_stall_o)
    else $error("block went idle before the last entry of a run");

endmodule
